// ===== rtl/tfmm_pkg.sv =====
// Shared types and codes for the transposed filter matrix multiply unit.
package tfmm_pkg;

    // Input item kinds, carried on the slave tuser
    localparam logic [1:0] OP_FILTER = 2'd0;
    localparam logic [1:0] OP_ADDEND = 2'd1;
    localparam logic [1:0] OP_DATA   = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_BLOCK_ORDER     = 2'd0;
    localparam logic [1:0] CFG_COLUMN_COUNT    = 2'd1;
    localparam logic [1:0] CFG_ACCUMULATE_MODE = 2'd2;

    // Hard limit on the filter order set by the 4-bit row/column fields
    localparam int FIELD_ROWS = 16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_EMIT_RD,
        ST_EMIT_LD
    } t_state;

    // Accumulator write-back from the MAC stage
    typedef struct packed {
        logic        vld;
        logic [3:0]  col;
        logic [63:0] sum;
    } t_wb;

endpackage

// ===== rtl/transposed_filter_matmul_unit.sv =====
// Top level: out = transpose(in) * filter with optional accumulate, Q16.16.
// Flow: a data element runs through MAC (one filter/sum memory read per accumulator,
//   one shared multiplier) and DRAIN; a data element that closes a column then gives
//   each output through EMIT_RD and EMIT_LD while the master takes them. Input is ready
//   only in idle. Filter, addend and ignored items leave the block idle, ready for the
//   next item.
// Reset: synchronous, active low; clears control, accumulator valid bits, addends,
//   column counter and registers (K=16, N=1, overwrite). Filter memory is not cleared.
module transposed_filter_matmul_unit #(
    parameter int MAX_ORDER   = 16,
    parameter int MAX_COLUMNS = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [12:0] i_cfg_data,
    // input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // row_index[3:0], col_index[7:4], value[39:8]
    input  logic [1:0]  s_axis_tuser,   // opcode[1:0]
    // result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // out_value[31:0], out_row[43:32], out_col[47:44]
    output logic        m_axis_tlast
);
    import tfmm_pkg::*;

    localparam int OW   = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int FD   = MAX_ORDER * MAX_ORDER;
    localparam int FAW  = (FD > 1) ? $clog2(FD) : 1;
    localparam int KLIM = (MAX_ORDER < FIELD_ROWS) ? MAX_ORDER : FIELD_ROWS;
    localparam int NW0  = $clog2(MAX_COLUMNS + 1);
    localparam int CNW  = (NW0 > 13) ? NW0 : 13;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [4:0]  r_block_order;
    logic [12:0] r_column_count;
    logic        r_acc_mode;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_order  <= 5'd16;
            r_column_count <= 13'd1;
            r_acc_mode     <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_BLOCK_ORDER:     r_block_order  <= i_cfg_data[4:0];
                CFG_COLUMN_COUNT:    r_column_count <= i_cfg_data;
                CFG_ACCUMULATE_MODE: r_acc_mode     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Effective order K: 0 acts as 1, clipped to the field limit and MAX_ORDER
    logic [4:0] w_k;
    logic [3:0] w_klast;
    always_comb begin
        if (r_block_order == 5'd0) begin
            w_k = 5'd1;
        end else if (int'(r_block_order) > KLIM) begin
            w_k = 5'(KLIM);
        end else begin
            w_k = r_block_order;
        end
        w_klast = 4'(w_k - 5'd1);
    end

    // Effective column count N
    logic [CNW-1:0] w_n;
    always_comb begin
        if (r_column_count == 13'd0) begin
            w_n = CNW'(1);
        end else if (CNW'(r_column_count) > CNW'(MAX_COLUMNS)) begin
            w_n = CNW'(MAX_COLUMNS);
        end else begin
            w_n = CNW'(r_column_count);
        end
    end

    // ------------------------------------------------------------------
    // Input fields
    // ------------------------------------------------------------------
    logic [3:0]  w_in_row;
    logic [3:0]  w_in_col;
    logic [31:0] w_in_value;
    logic        w_in_xfer;

    assign w_in_row   = s_axis_tdata[3:0];
    assign w_in_col   = s_axis_tdata[7:4];
    assign w_in_value = s_axis_tdata[39:8];
    assign w_in_xfer  = s_axis_tvalid && s_axis_tready;

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    t_state      r_state, n_state;
    logic [3:0]  r_c, n_c;          // accumulator / output column
    logic [3:0]  r_row;
    logic [31:0] r_data;
    logic [11:0] r_colcnt, n_colcnt;
    logic        w_rd_en;           // accumulator memory read this cycle
    logic        w_emit_clr;        // accumulator being emitted, drop its valid bit
    logic        w_out_load;
    logic        w_out_free;
    t_wb         w_wb;
    logic        r_s1_vld;
    logic [3:0]  r_s1_col;
    logic [CNW-1:0] w_cnt_nxt;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_out_free    = !m_axis_tvalid || m_axis_tready;
    assign w_cnt_nxt     = CNW'(r_colcnt) + CNW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_c      <= 4'd0;
            r_colcnt <= 12'd0;
        end else begin
            r_state  <= n_state;
            r_c      <= n_c;
            r_colcnt <= n_colcnt;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_c        = r_c;
        n_colcnt   = r_colcnt;
        w_rd_en    = 1'b0;
        w_emit_clr = 1'b0;
        w_out_load = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_in_xfer && s_axis_tuser == OP_DATA && {1'b0, w_in_row} < w_k) begin
                    n_state = ST_MAC;
                    n_c     = 4'd0;
                end
            end
            // one filter word and one accumulator read per cycle
            ST_MAC: begin
                w_rd_en = 1'b1;
                if (r_c == w_klast) begin
                    n_state = ST_DRAIN;
                    n_c     = 4'd0;
                end else begin
                    n_c = r_c + 4'd1;
                end
            end
            // wait for the last write-back before emitting or taking a new item
            ST_DRAIN: begin
                if (!r_s1_vld && !w_wb.vld) begin
                    n_state = (r_row == w_klast) ? ST_EMIT_RD : ST_IDLE;
                end
            end
            ST_EMIT_RD: begin
                if (w_out_free) begin
                    w_rd_en    = 1'b1;
                    w_emit_clr = 1'b1;
                    n_state    = ST_EMIT_LD;
                end
            end
            ST_EMIT_LD: begin
                w_out_load = 1'b1;
                if (r_c == w_klast) begin
                    n_state = ST_IDLE;
                    n_c     = 4'd0;
                    if (w_cnt_nxt >= w_n) begin
                        n_colcnt = 12'd0;
                    end else begin
                        n_colcnt = w_cnt_nxt[11:0];
                    end
                end else begin
                    n_state = ST_EMIT_RD;
                    n_c     = r_c + 4'd1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && w_in_xfer) begin
            r_row  <= w_in_row;
            r_data <= w_in_value;
        end
    end

    // ------------------------------------------------------------------
    // Filter memory: written by filter items, read during MAC
    // ------------------------------------------------------------------
    logic [31:0]    r_filter_mem [FD];
    logic [31:0]    r_rd_coef;
    logic [FAW-1:0] w_fwr_addr;
    logic [FAW-1:0] w_frd_addr;
    logic           w_fwr_en;

    assign w_fwr_addr = FAW'(int'(w_in_row) * MAX_ORDER + int'(w_in_col));
    assign w_frd_addr = FAW'(int'(r_row) * MAX_ORDER + int'(r_c));
    assign w_fwr_en   = w_in_xfer && s_axis_tuser == OP_FILTER &&
                        int'(w_in_row) < MAX_ORDER && int'(w_in_col) < MAX_ORDER;

    always_ff @(posedge i_clk) begin
        if (w_fwr_en) begin
            r_filter_mem[w_fwr_addr] <= w_in_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_coef <= r_filter_mem[w_frd_addr];
    end

    // ------------------------------------------------------------------
    // Accumulator memory, Q32.32; an entry without its valid bit reads zero
    // ------------------------------------------------------------------
    logic [63:0] r_sum_mem [MAX_ORDER];
    logic        r_sum_vld [MAX_ORDER];
    logic [63:0] r_rd_sum;
    logic        r_rd_svld;
    logic [63:0] w_sum_q;

    always_ff @(posedge i_clk) begin
        if (w_wb.vld) begin
            r_sum_mem[OW'(w_wb.col)] <= w_wb.sum;
        end
        r_rd_sum <= r_sum_mem[OW'(r_c)];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_ORDER; i++) begin
                r_sum_vld[i] <= 1'b0;
            end
            r_s1_vld <= 1'b0;
        end else begin
            if (w_wb.vld) begin
                r_sum_vld[OW'(w_wb.col)] <= 1'b1;
            end
            if (w_emit_clr) begin
                r_sum_vld[OW'(r_c)] <= 1'b0;
            end
            r_s1_vld <= w_rd_en && (r_state == ST_MAC);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rd_svld <= r_sum_vld[OW'(r_c)];
        end
        r_s1_col <= r_c;
    end

    assign w_sum_q = r_rd_svld ? r_rd_sum : 64'd0;

    tfmm_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_s1_vld),
        .i_col   (r_s1_col),
        .i_coef  (r_rd_coef),
        .i_data  (r_data),
        .i_sum   (w_sum_q),
        .o_wb    (w_wb)
    );

    // ------------------------------------------------------------------
    // Addends, kept until overwritten
    // ------------------------------------------------------------------
    logic [31:0] r_addend [MAX_ORDER];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_ORDER; i++) begin
                r_addend[i] <= 32'd0;
            end
        end else if (w_in_xfer && s_axis_tuser == OP_ADDEND && int'(w_in_col) < MAX_ORDER) begin
            r_addend[OW'(w_in_col)] <= w_in_value;
        end
    end

    // ------------------------------------------------------------------
    // Output: round half up to Q16.16, add addend, saturate to 32 bits
    // ------------------------------------------------------------------
    logic [49:0] w_fin;
    logic [31:0] w_add;
    logic [31:0] w_out_value;

    assign w_add = r_acc_mode ? r_addend[OW'(r_c)] : 32'd0;

    always_comb begin
        w_fin = {{2{w_sum_q[63]}}, w_sum_q[63:16]} + 50'(w_sum_q[15]) +
                {{18{w_add[31]}}, w_add};
        if (w_fin[49:31] == {19{1'b0}} || w_fin[49:31] == {19{1'b1}}) begin
            w_out_value = w_fin[31:0];
        end else if (w_fin[49]) begin
            w_out_value = 32'h8000_0000;
        end else begin
            w_out_value = 32'h7FFF_FFFF;
        end
    end

    logic        r_out_vld;
    logic [31:0] r_out_value;
    logic [11:0] r_out_row;
    logic [3:0]  r_out_col;
    logic        r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_out_load) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_value <= w_out_value;
            r_out_row   <= r_colcnt;
            r_out_col   <= r_c;
            r_out_last  <= (r_c == w_klast);
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {r_out_col, r_out_row, r_out_value};
    assign m_axis_tlast  = r_out_last;

endmodule

// ===== rtl/tfmm_mac.sv =====
// Multiply stage and saturating accumulate for one accumulator per cycle.
module tfmm_mac (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  logic [3:0]        i_col,
    input  logic [31:0]       i_coef,
    input  logic [31:0]       i_data,
    input  logic [63:0]       i_sum,
    output tfmm_pkg::t_wb     o_wb
);
    import tfmm_pkg::*;

    logic        r_vld;
    logic [3:0]  r_col;
    logic [63:0] r_prod;
    logic [63:0] r_sum;
    logic [63:0] w_add;
    logic        w_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_col  <= i_col;
        r_prod <= 64'($signed(i_coef) * $signed(i_data));
        r_sum  <= i_sum;
    end

    // saturate at the signed 64-bit limits
    always_comb begin
        w_add = r_sum + r_prod;
        w_ovf = (r_sum[63] == r_prod[63]) && (w_add[63] != r_sum[63]);
        o_wb.vld = r_vld;
        o_wb.col = r_col;
        if (w_ovf) begin
            o_wb.sum = r_sum[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end else begin
            o_wb.sum = w_add;
        end
    end

endmodule

// ===== rtl/tfmm_check.sv =====
// Port-level checks for the transposed filter matrix multiply unit.
module tfmm_check (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [1:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic        m_axis_tlast
);
    import tfmm_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // while a row is still being emitted, no new item is taken
    a_emit_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("input ready in the middle of an output row");

    // a non-final output never sits in the highest column
    a_last_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[47:44] != 4'hF)
        else $error("column 15 output without tlast");

    // a filter or addend load never stalls the input
    a_load_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready &&
        (s_axis_tuser == OP_FILTER || s_axis_tuser == OP_ADDEND) |=> s_axis_tready)
        else $error("load transfer stalled the input");

    // reset empties the output
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind transposed_filter_matmul_unit tfmm_check u_tfmm_check (.*);

// ===== tb/testbench.sv =====
// Self-checking testbench for the transposed filter matrix multiply unit.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import tfmm_pkg::*;

    localparam int ORDER_MAX  = 16;
    localparam int COLS_MAX   = 4096;
    localparam int SETTLE     = 80;    // quiet cycles before a register write
    localparam int DRAIN      = 100;   // cycles watched after the last result
    localparam int WDOG_LIMIT = 3000;  // cycles without any transfer
    localparam int RAND_DATA  = 160;   // minimum data elements in the random part

    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam longint S32_MAX = 64'sd2147483647;
    localparam longint S32_MIN = -64'sd2147483648;
    localparam longint S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint S64_MIN = 64'sh8000_0000_0000_0000;

    // One pending input transfer or register write
    typedef struct {
        bit          is_cfg;
        logic [1:0]  opcode;
        logic [3:0]  row;
        logic [3:0]  col;
        logic [31:0] value;
        logic [1:0]  reg_idx;
        logic [12:0] reg_data;
    } t_job;

    typedef struct {
        logic [31:0] value;
        logic [11:0] row;
        logic [3:0]  col;
        logic        last;
    } t_out;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_valid   = 1'b0;
    logic [1:0]  i_cfg_index   = '0;
    logic [12:0] i_cfg_data    = '0;
    logic        s_axis_tvalid = 1'b0;
    logic [39:0] s_axis_tdata  = '0;
    logic [1:0]  s_axis_tuser  = '0;
    logic        m_axis_tready = 1'b0;
    logic        o_cfg_ready;
    logic        s_axis_tready;
    logic        m_axis_tvalid;
    logic [47:0] m_axis_tdata;
    logic        m_axis_tlast;

    transposed_filter_matmul_unit #(
        .MAX_ORDER  (ORDER_MAX),
        .MAX_COLUMNS(COLS_MAX)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    t_job job_q[$];
    t_out matmul_out_q[$];
    int   errors = 0;

    // ---------------------------------------------------------------
    // Matmul predictor: its own filter/addend memories, Q32.32 sums,
    // column counter and register copies.
    // ---------------------------------------------------------------
    logic [31:0] flt_mem [ORDER_MAX*ORDER_MAX];
    logic [31:0] add_mem [ORDER_MAX];
    longint      sums    [ORDER_MAX];
    logic [11:0] col_ctr;
    logic [4:0]  order_reg;
    logic [12:0] ncols_reg;
    logic        accum_reg;

    function automatic int eff_order(logic [4:0] k);
        if (k == 0) return 1;
        if (k > ORDER_MAX) return ORDER_MAX;
        return int'(k);
    endfunction

    function automatic int eff_cols();
        if (ncols_reg == 0) return 1;
        if (ncols_reg > COLS_MAX) return COLS_MAX;
        return int'(ncols_reg);
    endfunction

    function automatic longint sat_add(longint a, longint b);
        longint r;
        r = a + b;
        if (a > 0 && b > 0 && r < 0) return S64_MAX;
        if (a < 0 && b < 0 && r >= 0) return S64_MIN;
        return r;
    endfunction

    // Q32.32 -> Q16.16 with round half up, plus addend, clamp to 32 bits
    function automatic logic [31:0] round_out(longint s, longint addend);
        longint r;
        r = (s >>> 16) + addend;
        if (s[15]) r = r + 1;
        if (r > S32_MAX) r = S32_MAX;
        if (r < S32_MIN) r = S32_MIN;
        return r[31:0];
    endfunction

    function automatic void matmul_reset();
        foreach (add_mem[i]) add_mem[i] = '0;
        foreach (sums[i]) sums[i] = 0;
        col_ctr   = '0;
        order_reg = 5'd16;
        ncols_reg = 13'd1;
        accum_reg = 1'b0;
    endfunction

    function automatic void matmul_cfg(logic [1:0] idx, logic [12:0] data);
        case (idx)
            CFG_BLOCK_ORDER:     order_reg = data[4:0];
            CFG_COLUMN_COUNT:    ncols_reg = data;
            CFG_ACCUMULATE_MODE: accum_reg = data[0];
            default: ;
        endcase
    endfunction

    function automatic void matmul_step(t_job j);
        int     k;
        longint d;
        longint f;
        longint addend;
        t_out   o;
        k = eff_order(order_reg);
        case (j.opcode)
            OP_FILTER: flt_mem[{j.row, j.col}] = j.value;
            OP_ADDEND: add_mem[j.col] = j.value;
            OP_DATA: begin
                if (int'(j.row) < k) begin
                    d = longint'(signed'(j.value));
                    for (int c = 0; c < k; c++) begin
                        f = longint'(signed'(flt_mem[int'(j.row) * ORDER_MAX + c]));
                        sums[c] = sat_add(sums[c], d * f);
                    end
                    // last row closes the column: one output word per filter column
                    if (int'(j.row) == k - 1) begin
                        for (int c = 0; c < k; c++) begin
                            addend  = accum_reg ? longint'(signed'(add_mem[c])) : 0;
                            o.value = round_out(sums[c], addend);
                            o.row   = col_ctr;
                            o.col   = 4'(c);
                            o.last  = (c == k - 1);
                            matmul_out_q.push_back(o);
                            sums[c] = 0;
                        end
                        if (int'(col_ctr) + 1 >= eff_cols()) col_ctr = '0;
                        else col_ctr = col_ctr + 1'b1;
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Stimulus building. gen_k tracks the order the queued writes set,
    // flt_seen which filter words have been loaded, so a data row never
    // reads an unloaded word.
    // ---------------------------------------------------------------
    int     gen_k = 16;
    bit     flt_seen [ORDER_MAX*ORDER_MAX];
    int     data_items = 0;

    function automatic logic [31:0] rand_word(bit mostly_small);
        if (mostly_small && $urandom_range(0, 3) != 0)
            return $urandom_range(0, 32'h3_FFFF) - 32'h2_0000;
        case ($urandom_range(0, 7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2, 3:    return $urandom_range(0, 32'h3_FFFF) - 32'h2_0000;
            default: return $urandom();
        endcase
    endfunction

    task automatic push_item(logic [1:0] op, int row, int col, logic [31:0] value);
        t_job j;
        j        = '{default: 0};
        j.opcode = op;
        j.row    = 4'(row);
        j.col    = 4'(col);
        j.value  = value;
        job_q.push_back(j);
        if (op == OP_FILTER) flt_seen[row * ORDER_MAX + col] = 1'b1;
        if (op == OP_DATA && row < gen_k) data_items++;
    endtask

    task automatic push_cfg(logic [1:0] idx, logic [12:0] data);
        t_job j;
        j          = '{default: 0};
        j.is_cfg   = 1'b1;
        j.reg_idx  = idx;
        j.reg_data = data;
        job_q.push_back(j);
        if (idx == CFG_BLOCK_ORDER) gen_k = eff_order(data[4:0]);
    endtask

    task automatic load_missing(int row);
        for (int c = 0; c < gen_k; c++)
            if (!flt_seen[row * ORDER_MAX + c])
                push_item(OP_FILTER, row, c, rand_word(1'b1));
    endtask

    task automatic push_column();
        for (int r = 0; r < gen_k; r++) begin
            load_missing(r);
            push_item(OP_DATA, r, $urandom_range(0, 15), rand_word(1'b0));
        end
    endtask

    task automatic push_noise();
        int r;
        case ($urandom_range(0, 4))
            0: push_item(OP_FILTER, $urandom_range(0, 15), $urandom_range(0, 15),
                         rand_word(1'b1));
            1: push_item(OP_ADDEND, $urandom_range(0, 15), $urandom_range(0, 15),
                         rand_word(1'b0));
            2: push_item(OP_UNUSED, $urandom_range(0, 15), $urandom_range(0, 15),
                         $urandom());
            3: begin
                // row beyond the order, dropped by the block (any row at the maximum order)
                r = (gen_k < ORDER_MAX) ? $urandom_range(gen_k, 15) : $urandom_range(0, 15);
                load_missing(r);
                push_item(OP_DATA, r, $urandom_range(0, 15), rand_word(1'b0));
            end
            default: begin
                // stray row: leaves a partial column behind unless it is the last row
                r = $urandom_range(0, gen_k - 1);
                load_missing(r);
                push_item(OP_DATA, r, $urandom_range(0, 15), rand_word(1'b0));
            end
        endcase
    endtask

    task automatic push_phase_cfg(int phase);
        logic [4:0]  k;
        logic [12:0] n;
        if (phase == 0) k = 5'd16;
        else if (phase == 1) k = 5'd0;
        else case ($urandom_range(0, 9))
            0:       k = 5'd1;
            1:       k = 5'd16;
            2:       k = 5'(17 + $urandom_range(0, 14));   // clamps to 16
            default: k = 5'($urandom_range(2, 6));
        endcase
        if (phase == 0) n = 13'd4096;
        else if (phase == 1) n = 13'($urandom_range(4097, 8191));   // clamps
        else case ($urandom_range(0, 5))
            0:       n = 13'd0;
            1:       n = 13'd1;
            default: n = 13'($urandom_range(2, 5));
        endcase
        if (phase < 2 || $urandom_range(0, 1))
            push_cfg(CFG_BLOCK_ORDER, {8'($urandom()), k});
        if (phase < 2 || $urandom_range(0, 1))
            push_cfg(CFG_COLUMN_COUNT, n);
        if (phase < 2 || $urandom_range(0, 1))
            push_cfg(CFG_ACCUMULATE_MODE, 13'($urandom()));
    endtask

    // ---------------------------------------------------------------
    // Driver: one transfer or register write at a time from job_q.
    // Register writes wait until no result is outstanding and the block
    // has had time to finish any column still in flight.
    // ---------------------------------------------------------------
    int send_gap  = 0;
    int quiet     = 0;
    int sent_cnt  = 0;

    function automatic int draw_gap(int count);
        if ((count / 50) % 3 == 0) return 0;   // stretches at full rate
        return $urandom_range(0, 3);
    endfunction

    always @(posedge i_clk) begin
        bit   s_nxt;
        bit   c_nxt;
        t_job j;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            i_cfg_valid   <= 1'b0;
            matmul_reset();
        end else begin
            s_nxt = s_axis_tvalid;
            c_nxt = i_cfg_valid;
            if (s_axis_tvalid && s_axis_tready) begin
                matmul_step(job_q.pop_front());
                s_nxt = 1'b0;
                sent_cnt++;
                send_gap = draw_gap(sent_cnt);
                quiet = 0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                j = job_q.pop_front();
                matmul_cfg(j.reg_idx, j.reg_data);
                c_nxt = 1'b0;
                send_gap = draw_gap(sent_cnt);
                quiet = 0;
            end
            if (!s_nxt && !c_nxt && job_q.size() != 0) begin
                if (send_gap != 0) begin
                    send_gap--;
                end else if (!job_q[0].is_cfg) begin
                    s_axis_tdata <= {job_q[0].value, job_q[0].col, job_q[0].row};
                    s_axis_tuser <= job_q[0].opcode;
                    s_nxt = 1'b1;
                end else if (matmul_out_q.size() != 0) begin
                    quiet = 0;
                end else if (quiet < SETTLE) begin
                    quiet++;
                end else begin
                    i_cfg_index <= job_q[0].reg_idx;
                    i_cfg_data  <= job_q[0].reg_data;
                    c_nxt = 1'b1;
                end
            end
            s_axis_tvalid <= s_nxt;
            i_cfg_valid   <= c_nxt;
        end
    end

    // ---------------------------------------------------------------
    // Monitor: random backpressure, field-by-field compare in order.
    // ---------------------------------------------------------------
    int take_gap = 0;
    int taken    = 0;

    function automatic int field_err(string what, logic [31:0] want, logic [31:0] got);
        if (want === got) return 0;
        $display("%0t: %s expected %h, got %h", $time, what, want, got);
        return 1;
    endfunction

    always @(posedge i_clk) begin
        t_out e;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                taken++;
                if (matmul_out_q.size() == 0) begin
                    errors++;
                    $display("%0t: result with none expected, expected nothing, got %h last %b",
                             $time, m_axis_tdata, m_axis_tlast);
                end else begin
                    e = matmul_out_q.pop_front();
                    errors += field_err("out_value", e.value, m_axis_tdata[31:0]);
                    errors += field_err("out_row", 32'(e.row), 32'(m_axis_tdata[43:32]));
                    errors += field_err("out_col", 32'(e.col), 32'(m_axis_tdata[47:44]));
                    errors += field_err("out_last", 32'(e.last), 32'(m_axis_tlast));
                end
                take_gap = ((taken / 40) % 3 == 0) ? 0 : $urandom_range(0, 3);
            end
            if (take_gap != 0) begin
                take_gap--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Watchdog: ends the run when nothing moves for too long
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (i_cfg_valid && o_cfg_ready)
                || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("%0t: timeout, %0d results outstanding", $time, matmul_out_q.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus and end of run
    // ---------------------------------------------------------------
    initial begin
        int phase;
        int target;
        foreach (flt_seen[i]) flt_seen[i] = 1'b0;

        // Directed: order 3, three columns per wrap, overwrite mode.
        push_cfg(CFG_BLOCK_ORDER, 13'd3);
        push_cfg(CFG_COLUMN_COUNT, 13'd3);
        push_cfg(CFG_ACCUMULATE_MODE, 13'd0);
        for (int r = 0; r < 3; r++) begin
            push_item(OP_FILTER, r, 0, 32'h8000_0000);
            push_item(OP_FILTER, r, 1, 32'h7FFF_FFFF);
            push_item(OP_FILTER, r, 2, 32'h0000_8000);
        end
        // most negative data: 64-bit sums saturate high and low, then clamp
        for (int r = 0; r < 3; r++) push_item(OP_DATA, r, 15, 32'h8000_0000);
        // half LSB on column 2 rounds up, then its negative rounds to zero
        push_item(OP_DATA, 0, 0, 32'h0000_0001);
        push_item(OP_DATA, 1, 0, 32'h0);
        push_item(OP_DATA, 2, 0, 32'h0);
        push_item(OP_DATA, 0, 0, 32'hFFFF_FFFF);
        push_item(OP_DATA, 1, 0, 32'h0);
        push_item(OP_DATA, 2, 0, 32'h0);
        // ignored: unused opcode and a row beyond the order
        push_item(OP_UNUSED, 15, 15, 32'hFFFF_FFFF);
        push_item(OP_DATA, 15, 0, 32'h7FFF_FFFF);
        // accumulate mode with extreme addends; counter wraps to row 0
        push_cfg(CFG_ACCUMULATE_MODE, 13'd1);
        push_item(OP_ADDEND, 0, 0, 32'h7FFF_FFFF);
        push_item(OP_ADDEND, 0, 2, 32'h8000_0000);
        push_item(OP_DATA, 0, 0, 32'h4000_0000);
        push_item(OP_DATA, 1, 0, 32'h7FFF_FFFF);
        push_item(OP_DATA, 2, 0, 32'h0001_0000);

        // Random: phases of settings, mostly whole columns with some noise.
        data_items = 0;
        phase = 0;
        while (data_items < RAND_DATA) begin
            push_phase_cfg(phase);
            target = data_items + $urandom_range(15, 30);
            while (data_items < target) begin
                if ($urandom_range(0, 4) != 0) push_column();
                else push_noise();
            end
            phase++;
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (job_q.size() != 0 || matmul_out_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);

        if (errors == 0 && matmul_out_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/tfmm_pkg.sv
rtl/tfmm_mac.sv
rtl/transposed_filter_matmul_unit.sv
rtl/tfmm_check.sv
tb/testbench.sv
